>>> rtl/assert_macros.svh
// assertion macros shared by the leg height balancer rtl
// no dependencies; expects clk and arst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AP_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define AP_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

>>> rtl/albh_pkg.sv
// types, constants and tables for the leg height balancer
// no dependencies
package albh_pkg;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQMUL,
		ST_PREP,
		ST_PMUL,
		ST_SQRT,
		ST_CINIT,
		ST_CITER,
		ST_GROLL,
		ST_GPITCH,
		ST_GINT,
		ST_EMIT
	} state_t;

	// configuration register indexes
	localparam logic [7:0] REG_ROLL_GAIN      = 8'd0;
	localparam logic [7:0] REG_PITCH_GAIN     = 8'd1;
	localparam logic [7:0] REG_OUTPUT_LIMIT   = 8'd2;
	localparam logic [7:0] REG_INTEGRAL_LIMIT = 8'd3;

	// cordic datapath widths
	localparam int CW = 38;
	localparam int ZW = 24;
	localparam logic signed [ZW-1:0] PI_Q20 = 24'sd3294199;
	localparam logic signed [32:0] INTEG_GAIN_Q16 = 33'sd1966;

	// arctangent of 2^-i, 20 fraction bits
	function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0:    r = 24'sd823550;
			5'd1:    r = 24'sd486170;
			5'd2:    r = 24'sd256879;
			5'd3:    r = 24'sd130396;
			5'd4:    r = 24'sd65451;
			5'd5:    r = 24'sd32757;
			5'd6:    r = 24'sd16383;
			5'd7:    r = 24'sd8192;
			5'd8:    r = 24'sd4096;
			5'd9:    r = 24'sd2048;
			5'd10:   r = 24'sd1024;
			5'd11:   r = 24'sd512;
			5'd12:   r = 24'sd256;
			5'd13:   r = 24'sd128;
			5'd14:   r = 24'sd64;
			5'd15:   r = 24'sd32;
			5'd16:   r = 24'sd16;
			5'd17:   r = 24'sd8;
			5'd18:   r = 24'sd4;
			5'd19:   r = 24'sd2;
			5'd20:   r = 24'sd1;
			default: r = 24'sd0;
		endcase
		return r;
	endfunction

	// symmetric saturation
	function automatic logic signed [25:0] clamp26(input logic signed [25:0] v,
			input logic [16:0] lim);
		logic signed [25:0] l;
		l = $signed({9'd0, lim});
		if (v > l)
			return l;
		else if (v < -l)
			return -l;
		return v;
	endfunction

endpackage

>>> rtl/attitude_leg_height_balancer_unit.sv
// top level of the leg height balancer: sequencer, shared multiplier, isqrt, cordic
// depends on albh_pkg and assert_macros.svh
`include "assert_macros.svh"

// Takes one attitude quaternion (Q2.14) per request and returns four saturated leg
// height offsets in micrometres. Roll and pitch come from an iterative CORDIC that
// runs CORDIC_STEPS vectoring steps for each angle; the pitch cosine term comes from
// a bit-pair integer square root of 32 steps. One multiplier serves all products.
// The time from accept until ready again is set mainly by the square root loop and the
// two CORDIC runs; an angle whose two operands are both zero skips its CORDIC steps,
// and the item takes longer while the previous result still waits. s_tready is high
// only while idle; a finished result waits in the output register. Configuration
// writes are taken only while idle.
module attitude_leg_height_balancer_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [20:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // quat_x, quat_y, quat_z, quat_w
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata   // front_left_dz, front_right_dz, rear_left_dz, rear_right_dz
);

	localparam int CW = albh_pkg::CW;
	localparam int ZW = albh_pkg::ZW;
	localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

	albh_pkg::state_t state_q, state_d;

	// configuration registers
	logic signed [20:0] roll_gain_q, pitch_gain_q;
	logic [16:0] output_limit_q;
	logic [15:0] integral_limit_q;

	// operands and intermediates
	logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
	logic signed [31:0] sq_q [8];
	logic [2:0]  k_q;
	logic signed [33:0] ry_q, rx_q;
	logic [31:0] pa_q, pb_q, mag_q;
	logic        a_neg_q;
	logic [63:0] v_q, r_q, bit_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0] cz_q;
	logic [4:0]  i_q;
	logic        which_q;
	logic signed [16:0] roll_q, pitch_q;
	logic signed [23:0] cr_q, cp_q;
	logic signed [16:0] integ_q;

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;

	assign s_tready  = (state_q == albh_pkg::ST_IDLE);
	assign cfg_ready = (state_q == albh_pkg::ST_IDLE);

	// operand selection for the multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			albh_pkg::ST_SQMUL: begin
				case (k_q)
					3'd0:    begin mul_a = 33'(qx_q); mul_b = 33'(qx_q); end
					3'd1:    begin mul_a = 33'(qy_q); mul_b = 33'(qy_q); end
					3'd2:    begin mul_a = 33'(qz_q); mul_b = 33'(qz_q); end
					3'd3:    begin mul_a = 33'(qw_q); mul_b = 33'(qw_q); end
					3'd4:    begin mul_a = 33'(qw_q); mul_b = 33'(qy_q); end
					3'd5:    begin mul_a = 33'(qx_q); mul_b = 33'(qz_q); end
					3'd6:    begin mul_a = 33'(qy_q); mul_b = 33'(qz_q); end
					default: begin mul_a = 33'(qw_q); mul_b = 33'(qx_q); end
				endcase
			end
			albh_pkg::ST_PMUL: begin
				mul_a = $signed({1'b0, pa_q});
				mul_b = $signed({1'b0, pb_q});
			end
			albh_pkg::ST_GROLL: begin
				mul_a = 33'(roll_gain_q);
				mul_b = 33'(-$signed({roll_q[16], roll_q}));
			end
			albh_pkg::ST_GPITCH: begin
				mul_a = 33'(pitch_gain_q);
				mul_b = 33'(pitch_q);
			end
			albh_pkg::ST_GINT: begin
				mul_a = 33'(cr_q);
				mul_b = albh_pkg::INTEG_GAIN_Q16;
			end
			default: ;
		endcase
	end
	assign prod = mul_a * mul_b;

	// angle setup from the squares and cross products
	logic signed [35:0] d_w, a_w, ry_w, rx_w, abs_a_w, dpa_w, dma_w;
	always_comb begin
		d_w  = 36'(sq_q[0]) + 36'(sq_q[1]) + 36'(sq_q[2]) + 36'(sq_q[3]);
		a_w  = (36'(sq_q[4]) - 36'(sq_q[5])) <<< 1;
		ry_w = (36'(sq_q[6]) + 36'(sq_q[7])) <<< 1;
		rx_w = d_w - ((36'(sq_q[0]) + 36'(sq_q[1])) <<< 1);
		abs_a_w = a_w[35] ? -a_w : a_w;
		dpa_w = d_w + a_w;
		dma_w = d_w - a_w;
	end

	// isqrt step
	logic [63:0] rb_w;
	assign rb_w = r_q + bit_q;

	// cordic setup and step
	logic signed [CW-1:0] yin_w, xin_w, dx_w, dy_w, cxn_w, cyn_w;
	logic signed [ZW-1:0] czn_w, zr_w;
	logic signed [16:0] ang_w;
	always_comb begin
		yin_w = which_q ? CW'($signed({1'b0, mag_q})) : CW'(ry_q);
		xin_w = which_q ? CW'($signed({1'b0, r_q[32:0]})) : CW'(rx_q);
		dx_w = cy_q >>> i_q;
		dy_w = cx_q >>> i_q;
		if (cy_q > 0) begin
			cxn_w = cx_q + dx_w;
			cyn_w = cy_q - dy_w;
			czn_w = cz_q + albh_pkg::atan_q20(i_q);
		end else begin
			cxn_w = cx_q - dx_w;
			cyn_w = cy_q + dy_w;
			czn_w = cz_q - albh_pkg::atan_q20(i_q);
		end
		zr_w  = czn_w + ZW'(64);
		ang_w = zr_w[23:7];
	end

	// gain rounding, integrator and leg mix
	logic signed [39:0] gr_w, ig_w;
	logic signed [19:0] isum_w;
	logic signed [25:0] ilim_w, e0_w, e1_w, e2_w, e3_w;
	always_comb begin
		gr_w   = prod[39:0] + 40'sd4096;
		ig_w   = prod[39:0] + 40'sd32768;
		isum_w = 20'(integ_q) + ig_w[35:16];
		ilim_w = albh_pkg::clamp26(26'(isum_w), {1'b0, integral_limit_q});
		e0_w = albh_pkg::clamp26(26'(cp_q) - 26'(cr_q) - 26'(integ_q), output_limit_q);
		e1_w = albh_pkg::clamp26(26'(cp_q) + 26'(cr_q) + 26'(integ_q), output_limit_q);
		e2_w = albh_pkg::clamp26(-26'(cp_q) - 26'(cr_q) - 26'(integ_q), output_limit_q);
		e3_w = albh_pkg::clamp26(-26'(cp_q) + 26'(cr_q) + 26'(integ_q), output_limit_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			albh_pkg::ST_IDLE:   if (s_tvalid) state_d = albh_pkg::ST_SQMUL;
			albh_pkg::ST_SQMUL:  if (k_q == 3'd7) state_d = albh_pkg::ST_PREP;
			albh_pkg::ST_PREP:   state_d = albh_pkg::ST_PMUL;
			albh_pkg::ST_PMUL:   state_d = albh_pkg::ST_SQRT;
			albh_pkg::ST_SQRT:   if (bit_q == 64'd1) state_d = albh_pkg::ST_CINIT;
			albh_pkg::ST_CINIT: begin
				if (xin_w == 0 && yin_w == 0)
					state_d = which_q ? albh_pkg::ST_GROLL : albh_pkg::ST_CINIT;
				else
					state_d = albh_pkg::ST_CITER;
			end
			albh_pkg::ST_CITER: begin
				if (i_q == LAST_STEP)
					state_d = which_q ? albh_pkg::ST_GROLL : albh_pkg::ST_CINIT;
			end
			albh_pkg::ST_GROLL:  state_d = albh_pkg::ST_GPITCH;
			albh_pkg::ST_GPITCH: state_d = albh_pkg::ST_GINT;
			albh_pkg::ST_GINT:   state_d = albh_pkg::ST_EMIT;
			albh_pkg::ST_EMIT:   if (!m_tvalid || m_tready) state_d = albh_pkg::ST_IDLE;
			default:             state_d = albh_pkg::ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= albh_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// configuration registers and integrator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_gain_q      <= '0;
			pitch_gain_q     <= '0;
			output_limit_q   <= 17'd50000;
			integral_limit_q <= 16'd20000;
			integ_q          <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					albh_pkg::REG_ROLL_GAIN:      roll_gain_q <= $signed(cfg_data);
					albh_pkg::REG_PITCH_GAIN:     pitch_gain_q <= $signed(cfg_data);
					albh_pkg::REG_OUTPUT_LIMIT:   output_limit_q <= cfg_data[16:0];
					albh_pkg::REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (state_q == albh_pkg::ST_GINT)
				integ_q <= ilim_w[16:0];
		end
	end

	// control counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			i_q      <= '0;
			which_q  <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (state_q == albh_pkg::ST_EMIT && (!m_tvalid || m_tready))
				m_tvalid <= 1'b1;
			else if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			case (state_q)
				albh_pkg::ST_IDLE: begin
					k_q     <= '0;
					which_q <= 1'b0;
				end
				albh_pkg::ST_SQMUL: k_q <= k_q + 3'd1;
				albh_pkg::ST_CINIT: begin
					i_q <= '0;
					if (xin_w == 0 && yin_w == 0)
						which_q <= 1'b1;
				end
				albh_pkg::ST_CITER: begin
					i_q <= i_q + 5'd1;
					if (i_q == LAST_STEP)
						which_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			albh_pkg::ST_IDLE: begin
				qx_q <= $signed(s_tdata[15:0]);
				qy_q <= $signed(s_tdata[31:16]);
				qz_q <= $signed(s_tdata[47:32]);
				qw_q <= $signed(s_tdata[63:48]);
			end
			albh_pkg::ST_SQMUL: sq_q[k_q] <= prod[31:0];
			albh_pkg::ST_PREP: begin
				ry_q    <= ry_w[33:0];
				rx_q    <= rx_w[33:0];
				pa_q    <= dpa_w[33:2];
				pb_q    <= dma_w[33:2];
				mag_q   <= abs_a_w[33:2];
				a_neg_q <= a_w[35];
			end
			albh_pkg::ST_PMUL: begin
				v_q   <= prod[63:0];
				r_q   <= '0;
				bit_q <= 64'd1 << 62;
			end
			albh_pkg::ST_SQRT: begin
				if (v_q >= rb_w) begin
					v_q <= v_q - rb_w;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			albh_pkg::ST_CINIT: begin
				if (xin_w == 0 && yin_w == 0) begin
					if (which_q)
						pitch_q <= '0;
					else
						roll_q <= '0;
				end else if (xin_w < 0) begin
					cx_q <= -xin_w;
					cy_q <= -yin_w;
					cz_q <= (yin_w >= 0) ? albh_pkg::PI_Q20 : -albh_pkg::PI_Q20;
				end else begin
					cx_q <= xin_w;
					cy_q <= yin_w;
					cz_q <= '0;
				end
			end
			albh_pkg::ST_CITER: begin
				cx_q <= cxn_w;
				cy_q <= cyn_w;
				cz_q <= czn_w;
				if (i_q == LAST_STEP) begin
					if (which_q)
						pitch_q <= a_neg_q ? -ang_w : ang_w;
					else
						roll_q <= ang_w;
				end
			end
			albh_pkg::ST_GROLL:  cr_q <= gr_w[36:13];
			albh_pkg::ST_GPITCH: cp_q <= gr_w[36:13];
			albh_pkg::ST_EMIT: begin
				if (!m_tvalid || m_tready)
					m_tdata <= {e3_w[17:0], e2_w[17:0], e1_w[17:0], e0_w[17:0]};
			end
			default: ;
		endcase
	end

	// checks
	`AP_IMPL(a_rise_from_emit, $rose(m_tvalid), $past(state_q) == albh_pkg::ST_EMIT)
	`AP_IMPL(a_sqrt_onehot, state_q == albh_pkg::ST_SQRT, $onehot(bit_q))
	`AP_NEXT(a_accept_starts, s_tvalid && s_tready, state_q == albh_pkg::ST_SQMUL && k_q == 3'd0)

endmodule
